// ===== rtl/disk_track_header_encoder_macros.svh =====
// Assertion macros shared by the header encoder RTL.
// Depends on nothing; included by the files that assert.
`ifndef DISK_TRACK_HEADER_ENCODER_MACROS_SVH
`define DISK_TRACK_HEADER_ENCODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTHE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("header encoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define DTHE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("header encoder check failed");

`endif

// ===== rtl/dthe_pkg.sv =====
// Types, constants and word-forming functions of the track header encoder.
// Depends on nothing.
package dthe_pkg;

  localparam int unsigned CylW  = 8;
  localparam int unsigned HeadW = 4;
  localparam int unsigned AddrW = 30;
  localparam int unsigned WordW = 50;

  localparam logic [9:0]  SpareZone  = 10'd1000;
  localparam logic [12:0] RecipTen   = 13'd6554;
  localparam logic [47:0] Word0Base  = 48'o7404000000000000;
  localparam logic [47:0] Word1Val   = 48'o3740;
  localparam logic [47:0] Word2Base  = 48'o0400000000037777;
  localparam logic [47:0] Word3Val   = {48{1'b1}};
  localparam logic [1:0]  NumberTag  = 2'd2;

  localparam logic [1:0] WordAddr  = 2'd0;
  localparam logic [1:0] WordMark  = 2'd1;
  localparam logic [1:0] WordCheck = 2'd2;
  localparam logic [1:0] WordFill  = 2'd3;

  typedef struct packed {
    logic             spare;
    logic [CylW-1:0]  cyl;
    logic [HeadW-1:0] head;
  } entry_t;

  // Sum in which every carry moves one place toward bit 0.
  function automatic logic [5:0] add_carry_right(logic [5:0] x, logic [5:0] y);
    logic [5:0] a;
    logic [5:0] b;
    logic [5:0] cy;
    a = x;
    b = y;
    for (int n = 0; n < 6; n++) begin
      cy = a & b;
      a  = a ^ b;
      b  = cy >> 1;
    end
    return a;
  endfunction

  // Address word with spare flag and inverted checksum in the low 12 bits.
  function automatic logic [AddrW-1:0] make_addr(entry_t e);
    logic [AddrW-1:0] a;
    logic [5:0]       s;
    a = '0;
    a[27:20] = e.cyl;
    a[19:16] = e.head;
    a[29]    = e.spare;
    s = add_carry_right(a[17:12], a[29:24]);
    a[11:0] = ~{a[23:18], s};
    return a;
  endfunction

  // 5 x 9 transpose: bit i*9+j goes to bit i+j*5.
  function automatic logic [44:0] comb_encode(logic [47:0] v);
    logic [44:0] r;
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 9; j++) begin
        r[i + j * 5] = v[i * 9 + j];
      end
    end
    return r;
  endfunction

  function automatic logic [WordW-1:0] header_word(logic [1:0] k, logic [AddrW-1:0] a);
    logic [47:0] raw;
    case (k)
      WordAddr:  raw = Word0Base | {10'd0, a, 8'd0};
      WordMark:  raw = Word1Val;
      WordCheck: raw = Word2Base | {4'd0, a, 14'd0};
      WordFill:  raw = Word3Val;
      default:   raw = Word3Val;
    endcase
    return {NumberTag, 3'd0, comb_encode(raw)};
  endfunction

endpackage

// ===== rtl/dthe_if.sv =====
// Valid/ready channel interfaces for requests and header words.
// Depends on dthe_pkg for the word width.
interface dthe_req_if;
  logic       valid;
  logic       ready;
  logic [9:0] zone_number;
  logic       half_zone;
  modport source (output valid, zone_number, half_zone, input ready);
  modport sink   (input valid, zone_number, half_zone, output ready);
endinterface

interface dthe_hdr_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    word_index;
  logic [dthe_pkg::WordW-1:0]    header_word;
  logic                          last_word;
  modport source (output valid, word_index, header_word, last_word, input ready);
  modport sink   (input valid, word_index, header_word, last_word, output ready);
endinterface

// ===== rtl/dthe_front.sv =====
// Request front end: splits the head index into cylinder and head.
// Depends on dthe_pkg and dthe_req_if.
module dthe_front (
  dthe_req_if.sink          req,
  input  logic              full_i,
  output logic              push_o,
  output dthe_pkg::entry_t  entry_o
);

  logic [10:0] idx;
  logic [23:0] prod;
  logic [7:0]  cyl;
  logic [10:0] cyl_x10;
  logic [10:0] rem;

  // Reciprocal multiply is exact for every 11-bit index.
  assign idx     = {req.zone_number, req.half_zone};
  assign prod    = {13'd0, idx} * {11'd0, dthe_pkg::RecipTen};
  assign cyl     = prod[23:16];
  assign cyl_x10 = {cyl, 3'd0} + {2'd0, cyl, 1'b0};
  assign rem     = idx - cyl_x10;

  assign req.ready     = !full_i;
  assign push_o        = req.valid && !full_i;
  assign entry_o.cyl   = cyl;
  assign entry_o.head  = rem[3:0];
  assign entry_o.spare = (req.zone_number >= dthe_pkg::SpareZone);

endmodule

// ===== rtl/dthe_fifo.sv =====
// Short queue of classified requests between front and back.
// Depends on dthe_pkg.
module dthe_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dthe_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output dthe_pkg::entry_t entry_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  dthe_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/dthe_back.sv =====
// Word sequencer: forms the address word and issues the four header words.
// Depends on dthe_pkg, dthe_hdr_if and the assertion macro header.
`include "disk_track_header_encoder_macros.svh"

module dthe_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  dthe_pkg::entry_t entry_i,
  output logic             pop_o,
  dthe_hdr_if.source       hdr
);

  logic                         load;
  logic                         busy_q;
  logic [1:0]                   cnt_q;
  logic [dthe_pkg::AddrW-1:0]   addr_q;
  logic [dthe_pkg::AddrW-1:0]   new_addr;
  logic                         out_valid_q;
  logic [1:0]                   idx_q;
  logic [dthe_pkg::WordW-1:0]   word_q;

  // The output register is refilled whenever it is empty or being taken.
  assign load     = !out_valid_q || hdr.ready;
  assign pop_o    = load && !busy_q && valid_i;
  assign new_addr = dthe_pkg::make_addr(entry_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      if (busy_q) begin
        out_valid_q <= 1'b1;
        cnt_q       <= cnt_q + 1'b1;
        if (cnt_q == dthe_pkg::WordFill) begin
          busy_q <= 1'b0;
        end
      end else if (valid_i) begin
        out_valid_q <= 1'b1;
        cnt_q       <= dthe_pkg::WordMark;
        busy_q      <= 1'b1;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (busy_q) begin
        idx_q  <= cnt_q;
        word_q <= dthe_pkg::header_word(cnt_q, addr_q);
      end else if (valid_i) begin
        addr_q <= new_addr;
        idx_q  <= dthe_pkg::WordAddr;
        word_q <= dthe_pkg::header_word(dthe_pkg::WordAddr, new_addr);
      end
    end
  end

  assign hdr.valid       = out_valid_q;
  assign hdr.word_index  = idx_q;
  assign hdr.header_word = word_q;
  assign hdr.last_word   = (idx_q == dthe_pkg::WordFill);

  `DTHE_ASSERT_SAME(a_busy_has_word, clk_i, rst_ni, busy_q, out_valid_q)
  `DTHE_ASSERT_SAME(a_pop_only_idle, clk_i, rst_ni, pop_o, !busy_q)
  `DTHE_ASSERT_NEXT(a_words_in_order, clk_i, rst_ni,
    out_valid_q && hdr.ready && (idx_q != dthe_pkg::WordFill),
    out_valid_q && (idx_q == 2'($past(idx_q) + 2'd1)))

endmodule

// ===== rtl/disk_track_header_encoder.sv =====
// Disk track header encoder, top level.
// Request channel: a word carries zone_number and half_zone. Each accepted
// request produces four header words on the output channel, word_index 0
// to 3 in order, with last_word high on the fourth one.
// The front splits the head index (zone*2+track) into cylinder and head in
// the cycle the request is taken and writes it into a short queue. The back
// pops one entry, builds the address word with its checksum, and issues one
// header word per cycle from an output register while the receiver is ready.
// With the queue empty and the back idle, an accepted request is written
// into the queue, then popped into the output register, which shows its
// first word; the other three follow in order.
// The single output port moves one header word per cycle while the receiver
// is ready, so each request occupies it for all four of its words.
// Requests are taken while earlier words are still being delivered until
// the queue holds QueueDepth entries.
// When the receiver stalls, the shown word holds and the sequence pauses;
// the queue then fills and the request ready drops.
// Reset empties the queue and the output register; no word is in flight
// afterward. Depends on dthe_pkg, the interfaces and the submodules.
module disk_track_header_encoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dthe_req_if.sink    req_i,
  dthe_hdr_if.source  hdr_o
);

  logic             push;
  logic             full;
  logic             pop;
  logic             q_valid;
  dthe_pkg::entry_t push_entry;
  dthe_pkg::entry_t head_entry;

  dthe_front u_front (
    .req     (req_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  dthe_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  dthe_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .entry_i (head_entry),
    .pop_o   (pop),
    .hdr     (hdr_o)
  );

endmodule

// ===== tb/disk_track_header_encoder_tb.sv =====
// Self-checking testbench for the disk track header encoder.
// Depends on dthe_pkg, dthe_if.sv and the encoder RTL; predicts the four
// header words of every accepted request and checks each delivered word.
module disk_track_header_encoder_tb;

  localparam int unsigned WordW      = dthe_pkg::WordW;
  localparam logic [9:0]  SpareFrom  = 10'd1000;
  localparam logic [63:0] AddrBase   = 64'o07404000000000000;
  localparam logic [63:0] MarkWord   = 64'o03740;
  localparam logic [63:0] CheckBase  = 64'o00400000000037777;
  localparam logic [63:0] FillWord   = 64'hFFFF_FFFF_FFFF;
  localparam logic [1:0]  TagNumber  = 2'd2;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned MaxReports = 40;

  class header_word_tracker;
    typedef struct {
      logic [1:0]       index;
      logic [WordW-1:0] word;
      logic             last;
    } header_word_t;

    header_word_t due_words[$];
    int unsigned  failures;

    function new();
      failures = 0;
    endfunction

    // Addition where each carry moves one place toward bit 0.
    function automatic logic [31:0] sum_carry_down(logic [31:0] x, logic [31:0] y);
      logic [31:0] c;
      for (int n = 0; n < 33; n++) begin
        if (y != 0) begin
          c = x & y;
          x = x ^ y;
          y = c >> 1;
        end
      end
      return x;
    endfunction

    function automatic logic [31:0] track_address(logic [9:0] zone, logic half);
      logic [10:0] head_index;
      logic [7:0]  cyl;
      logic [3:0]  head;
      logic [31:0] a;
      logic [31:0] sum;
      head_index = {zone, half};
      cyl  = 8'(head_index / 11'd10);
      head = 4'(head_index % 11'd10);
      a = (32'(cyl) << 20) | (32'(head) << 16);
      if (zone >= SpareFrom) a[29] = 1'b1;
      sum = sum_carry_down(a >> 12, a >> 24);
      a[11:0] = a[11:0] | ~sum[11:0];
      return a;
    endfunction

    // Bits 0..44 are transposed as a 5 by 9 array; the tag goes on top.
    function automatic logic [WordW-1:0] tagged_comb(logic [63:0] raw);
      logic [44:0] r;
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 9; j++) begin
          r[i + 5 * j] = raw[9 * i + j];
        end
      end
      return {TagNumber, 3'd0, r};
    endfunction

    function void note_request(logic [9:0] zone, logic half);
      logic [31:0]  a;
      logic [63:0]  raw;
      logic [1:0]   k;
      header_word_t w;
      a = track_address(zone, half);
      for (int n = 0; n < 4; n++) begin
        k = 2'(n);
        case (k)
          dthe_pkg::WordAddr:  raw = AddrBase | (64'(a) << 8);
          dthe_pkg::WordMark:  raw = MarkWord;
          dthe_pkg::WordCheck: raw = CheckBase | (64'(a) << 14);
          default:             raw = FillWord;
        endcase
        w.index = k;
        w.word  = tagged_comb(raw);
        w.last  = (k == dthe_pkg::WordFill);
        due_words.push_back(w);
      end
    endfunction

    function void check_word(logic [1:0] index, logic [WordW-1:0] word, logic last);
      header_word_t w;
      if (due_words.size() == 0) begin
        if (failures < MaxReports)
          $display("%0t: unexpected word index %0d word %h last %b", $time, index, word, last);
        failures++;
        return;
      end
      w = due_words.pop_front();
      if (index !== w.index) begin
        if (failures < MaxReports)
          $display("%0t: word_index expected %0d, got %0d", $time, w.index, index);
        failures++;
      end
      if (word !== w.word) begin
        if (failures < MaxReports)
          $display("%0t: header_word expected %h, got %h", $time, w.word, word);
        failures++;
      end
      if (last !== w.last) begin
        if (failures < MaxReports)
          $display("%0t: last_word expected %b, got %b", $time, w.last, last);
        failures++;
      end
    endfunction

    function int unsigned words_pending();
      return due_words.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic req_taken;
  logic hold_words;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles;
  header_word_tracker tracker;

  dthe_req_if req_ch ();
  dthe_hdr_if hdr_ch ();

  disk_track_header_encoder dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .hdr_o  (hdr_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both channels are sampled here, before the design's own updates land.
  always @(posedge clk) begin
    req_taken = 1'b0;
    if (rst_n) begin
      req_taken = req_ch.valid && req_ch.ready;
      if (req_taken) tracker.note_request(req_ch.zone_number, req_ch.half_zone);
      if (hdr_ch.valid && hdr_ch.ready)
        tracker.check_word(hdr_ch.word_index, hdr_ch.header_word, hdr_ch.last_word);
      if (req_taken || (hdr_ch.valid && hdr_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // Receiver: random stalls, or one long hold-off when asked for.
  initial begin
    hdr_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_words) begin
        hdr_ch.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_words = 1'b0;
      end else begin
        hdr_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic offer_request(input logic [9:0] zone, input logic half);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_ch.valid       <= 1'b1;
    req_ch.zone_number <= zone;
    req_ch.half_zone   <= half;
    do @(negedge clk); while (!req_taken);
  endtask

  // Mostly uniform zones, with extra weight near both ends and the spare boundary.
  task automatic offer_random();
    logic [9:0] zone;
    case ($urandom_range(0, 9))
      7:       zone = 10'($urandom_range(990, 1023));
      8:       zone = 10'($urandom_range(0, 15));
      9:       zone = 10'($urandom_range(995, 1005));
      default: zone = 10'($urandom);
    endcase
    offer_request(zone, 1'($urandom));
  endtask

  initial begin
    rst_n              = 1'b0;
    req_taken          = 1'b0;
    hold_words         = 1'b0;
    quiet_cycles       = 0;
    send_idle_pct      = 0;
    stall_pct          = 0;
    req_ch.valid       = 1'b0;
    req_ch.zone_number = '0;
    req_ch.half_zone   = 1'b0;
    tracker = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: both ends of the range, the spare-zone boundary and the
    // points where the head index rolls over into a new cylinder.
    offer_request(10'd0, 1'b0);
    offer_request(10'd0, 1'b1);
    offer_request(10'd4, 1'b1);
    offer_request(10'd5, 1'b0);
    offer_request(10'd511, 1'b1);
    offer_request(10'd512, 1'b0);
    offer_request(10'd999, 1'b0);
    offer_request(10'd999, 1'b1);
    offer_request(10'd1000, 1'b0);
    offer_request(10'd1000, 1'b1);
    offer_request(10'd1001, 1'b1);
    offer_request(10'd1022, 1'b0);
    offer_request(10'd1023, 1'b0);
    offer_request(10'd1023, 1'b1);
    offer_request(10'd682, 1'b1);
    offer_request(10'd341, 1'b0);

    send_idle_pct = 0;  stall_pct = 0;
    repeat (80) offer_random();
    send_idle_pct = 80; stall_pct = 0;
    repeat (80) offer_random();
    send_idle_pct = 0;  stall_pct = 80;
    repeat (80) offer_random();
    send_idle_pct = 10; stall_pct = 10;
    repeat (80) offer_random();

    // The receiver holds off while requests keep coming, so the queue fills.
    send_idle_pct = 0;
    hold_words = 1'b1;
    repeat (12) offer_random();
    repeat (20) offer_random();

    req_ch.valid <= 1'b0;
    while (tracker.words_pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (tracker.failures == 0 && tracker.words_pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
